// ===== src/wpar_pkg.sv =====
// ----------------------------------------------------------------------------
// wpar_pkg: shared types and constants of the weighted pixel film buffer
// Item and result structs, stored entry layout, status codes and widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpar_pkg;

  // Default film size
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Field and sum widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 48;
  localparam int WSUM_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int REG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CH   = 3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0]     IMAGE_WIDTH_RST  = 7'd64;
  localparam logic [REG_W-1:0]     IMAGE_HEIGHT_RST = 7'd64;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NO_WEIGHT = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  // Saturation bounds
  localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [WSUM_W-1:0]       WSUM_MAX = {WSUM_W{1'b1}};
  localparam logic [BYTE_W-1:0]       BYTE_MAX = 8'd255;

  // Input item
  typedef struct packed {
    logic                       mode;
    logic [POS_W-1:0]           x_pos;
    logic [POS_W-1:0]           y_pos;
    logic signed [SAMPLE_W-1:0] sample_red;
    logic signed [SAMPLE_W-1:0] sample_green;
    logic signed [SAMPLE_W-1:0] sample_blue;
    logic [SAMPLE_W-1:0]        sample_weight;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] pixel_red;
    logic [BYTE_W-1:0] pixel_green;
    logic [BYTE_W-1:0] pixel_blue;
    logic [POS_W-1:0]  image_row;
  } result_t;

  // One stored pixel
  typedef struct packed {
    logic signed [SUM_W-1:0] red_sum;
    logic signed [SUM_W-1:0] green_sum;
    logic signed [SUM_W-1:0] blue_sum;
    logic [WSUM_W-1:0]       weight_sum;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== src/wpar_ram.sv =====
// ----------------------------------------------------------------------------
// wpar_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpar_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/wpar_div.sv =====
// ----------------------------------------------------------------------------
// wpar_div: iterative resolve divider
// Computes min(floor(sum*255 / (wsum*4096)), 255), zero for sum <= 0,
// one restoring step per cycle, shared by the three color channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpar_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [wpar_pkg::SUM_W-1:0]  sum,
  input  wire logic        [wpar_pkg::WSUM_W-1:0] wsum,
  output logic                               done,
  output logic             [wpar_pkg::BYTE_W-1:0] quotient
);

  import wpar_pkg::*;

  // Remainder holds sum*255, divisor starts at (wsum << 12) << 8
  localparam int MAG_W  = SUM_W - 1;
  localparam int REM_W  = MAG_W + BYTE_W;
  localparam int DEN_W  = WSUM_W + 12 + BYTE_W;
  localparam logic [3:0] TOP_STEP = 4'(BYTE_W);

  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [3:0]       step;
  logic             run;
  logic [REM_W-1:0] den_ext;
  logic             ge;
  logic [MAG_W-1:0] mag;

  assign mag     = sum[MAG_W-1:0];
  assign den_ext = REM_W'(den);
  assign ge      = (rem >= den_ext);

  // Control: run flag, step count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sum[SUM_W-1] || (sum == '0)) begin
          done <= 1'b1;
        end else begin
          run  <= 1'b1;
          step <= TOP_STEP;
        end
      end else if (run) begin
        if ((step == TOP_STEP) && ge) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else if (step == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 4'd1;
        end
      end
    end
  end

  // Datapath: one compare and subtract per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {mag, {BYTE_W{1'b0}}} - REM_W'(mag);
      den      <= {wsum, {(12 + BYTE_W){1'b0}}};
      quotient <= '0;
    end else if (run) begin
      den <= den >> 1;
      if (step == TOP_STEP) begin
        // quotient of 256 or more clamps
        if (ge) begin
          quotient <= BYTE_MAX;
        end
      end else begin
        quotient <= {quotient[BYTE_W-2:0], ge};
        if (ge) begin
          rem <= rem - den_ext;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/weighted_pixel_accumulate_resolve_top.sv =====
// ----------------------------------------------------------------------------
// weighted_pixel_accumulate_resolve_top: weighted sample film buffer
// Accumulates weighted RGB samples per pixel and resolves pixels to bytes.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                 Handshake
// command   start, busy, cmd                        taken when start & !busy
// result    done, result                            one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  valid & ready
//
// An out-of-range item goes straight to its result; an add item reads
// the entry, multiplies and accumulates each channel, then writes it
// back; resolving a weighted pixel runs the shared divider per channel.
// Adds run the single multiplier once per channel, then a saturating add.
// Reset: after rst the pixel memory is cleared one entry per cycle,
// MAX_WIDTH*MAX_HEIGHT entries (4096 by default); busy stays high meanwhile.
// Config writes are always taken. The result side cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module weighted_pixel_accumulate_resolve_top #(
  parameter int MAX_WIDTH  = wpar_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wpar_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire wpar_pkg::cmd_t                     cmd,
  output logic                                    done,
  output wpar_pkg::result_t                       result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wpar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wpar_pkg::REG_W-1:0]         cfg_data
);

  import wpar_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = 11;
  localparam logic [1:0] LAST_CH = 2'(NUM_CH - 1);

  // Sequencer codes
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_READ     = 4'd2;
  localparam logic [3:0] S_LOAD     = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_ACC      = 4'd5;
  localparam logic [3:0] S_WSUM     = 4'd6;
  localparam logic [3:0] S_WRITE    = 4'd7;
  localparam logic [3:0] S_DIV_GO   = 4'd8;
  localparam logic [3:0] S_DIV_WAIT = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;

  cmd_t             cmd_r;
  logic [AW-1:0]    addr_r;
  logic [1:0]       ch;
  logic             sat_r;
  logic [1:0]       status_r;
  logic [POS_W-1:0] row_r;
  logic [BYTE_W-1:0] px [NUM_CH];

  logic signed [SUM_W-1:0] sum_r [NUM_CH];
  logic [WSUM_W-1:0]       wsum_r;
  logic signed [32:0]      prod_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position check, flipped row and pixel address
  logic [CW-1:0] w_eff, h_eff;
  logic          in_range;
  logic [POS_W-1:0] row_calc;
  logic [AW-1:0] addr_calc;

  assign w_eff = (CW'(image_width) < CW'(MAX_WIDTH)) ? CW'(image_width) : CW'(MAX_WIDTH);
  assign h_eff = (CW'(image_height) < CW'(MAX_HEIGHT)) ? CW'(image_height)
                                                       : CW'(MAX_HEIGHT);
  assign in_range  = (CW'(cmd.x_pos) < w_eff) && (CW'(cmd.y_pos) < h_eff);
  assign row_calc  = POS_W'(h_eff - CW'(1) - CW'(cmd.y_pos));
  assign addr_calc = AW'(AW'(cmd.y_pos) * AW'(MAX_WIDTH) + AW'(cmd.x_pos));

  // Pixel memory
  entry_t        rd_entry;
  entry_t        wr_entry;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr_r;

  always_comb begin
    wr_entry = '0;
    if (state != S_CLEAR) begin
      wr_entry.red_sum    = sum_r[0];
      wr_entry.green_sum  = sum_r[1];
      wr_entry.blue_sum   = sum_r[2];
      wr_entry.weight_sum = wsum_r;
    end
  end

  wpar_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (addr_r),
    .rdata (rd_entry)
  );

  // Shared resolve divider
  logic              div_start;
  logic              div_done;
  logic [BYTE_W-1:0] div_q;

  assign div_start = (state == S_DIV_GO);

  wpar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (sum_r[ch]),
    .wsum     (wsum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Channel sample select and saturating sums
  logic signed [SAMPLE_W-1:0] samp_sel;
  logic signed [SUM_W:0]      acc_wide;
  logic signed [SUM_W-1:0]    acc_sat;
  logic                       acc_ovf;
  logic [WSUM_W:0]            ws_wide;
  logic                       rd_bound;

  always_comb begin
    case (ch)
      2'd0:    samp_sel = cmd_r.sample_red;
      2'd1:    samp_sel = cmd_r.sample_green;
      default: samp_sel = cmd_r.sample_blue;
    endcase
  end

  assign acc_wide = {sum_r[ch][SUM_W-1], sum_r[ch]} + (SUM_W + 1)'(prod_r);
  assign acc_ovf  = acc_wide[SUM_W] != acc_wide[SUM_W-1];
  assign acc_sat  = !acc_ovf ? acc_wide[SUM_W-1:0] :
                    (acc_wide[SUM_W] ? SUM_MIN : SUM_MAX);
  assign ws_wide  = {1'b0, wsum_r} + (WSUM_W + 1)'(cmd_r.sample_weight);

  // Any stored sum pinned at a bound
  assign rd_bound = (rd_entry.weight_sum == WSUM_MAX) ||
                    (rd_entry.red_sum == SUM_MAX) || (rd_entry.red_sum == SUM_MIN) ||
                    (rd_entry.green_sum == SUM_MAX) || (rd_entry.green_sum == SUM_MIN) ||
                    (rd_entry.blue_sum == SUM_MAX) || (rd_entry.blue_sum == SUM_MIN);

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ch       <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= in_range ? S_READ : S_DONE;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          ch <= '0;
          if (!cmd_r.mode) begin
            state <= S_MUL;
          end else if (rd_entry.weight_sum == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_DIV_GO;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (ch == LAST_CH) begin
            state <= S_WSUM;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_MUL;
          end
        end
        S_WSUM:   state <= S_WRITE;
        S_WRITE:  state <= S_DONE;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (ch == LAST_CH) begin
              state <= S_DONE;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_DIV_GO;
            end
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r  <= cmd;
          addr_r <= addr_calc;
          sat_r  <= 1'b0;
          for (int i = 0; i < NUM_CH; i++) begin
            px[i] <= '0;
          end
          status_r <= in_range ? ST_OK : ST_RANGE;
          row_r    <= in_range ? row_calc : '0;
        end
      end
      S_LOAD: begin
        sum_r[0] <= rd_entry.red_sum;
        sum_r[1] <= rd_entry.green_sum;
        sum_r[2] <= rd_entry.blue_sum;
        wsum_r   <= rd_entry.weight_sum;
        if (cmd_r.mode) begin
          if (rd_entry.weight_sum == '0) begin
            status_r <= ST_NO_WEIGHT;
          end else begin
            status_r <= rd_bound ? ST_SAT : ST_OK;
          end
        end
      end
      S_MUL: prod_r <= samp_sel * $signed({1'b0, cmd_r.sample_weight});
      S_ACC: begin
        sum_r[ch] <= acc_sat;
        sat_r     <= sat_r | acc_ovf;
      end
      S_WSUM: begin
        if (ws_wide[WSUM_W]) begin
          wsum_r <= WSUM_MAX;
          sat_r  <= 1'b1;
        end else begin
          wsum_r <= ws_wide[WSUM_W-1:0];
        end
      end
      S_WRITE: status_r <= sat_r ? ST_SAT : ST_OK;
      S_DIV_WAIT: begin
        if (div_done) begin
          px[ch] <= div_q;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    result.status      = status_r;
    result.pixel_red   = px[0];
    result.pixel_green = px[1];
    result.pixel_blue  = px[2];
    result.image_row   = row_r;
  end

  // Checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy right after an accepted item");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider finished outside of its wait state");

  a_range_black: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_RANGE)) |->
      ((result.pixel_red == '0) && (result.pixel_green == '0) &&
       (result.pixel_blue == '0) && (result.image_row == '0)))
    else $error("out-of-range result carries data");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: weighted pixel film buffer
// Drives add and resolve items through the command port, writes the size
// registers between phases, and checks every result against a per-pixel
// model of the film sums kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import wpar_pkg::*;

  localparam logic                 MODE_ADD     = 1'b0;
  localparam logic                 MODE_RESOLVE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int     PIXELS   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam longint ACC_TOP  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOT  = -ACC_TOP - 1;
  localparam longint WACC_TOP = 64'sh0000_0000_FFFF_FFFF;

  localparam int SETTLE_CYCLES = 40;     // longest item is a resolve
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SHOWN_MAX     = 40;
  localparam int HOT_SLOTS     = 6;
  localparam int PAUSE_AT      = 200;

  // Random phases: register values, item count, sender idle percentage
  localparam int NUM_PHASES = 7;
  localparam int PH_W [NUM_PHASES] = '{64, 1, 127, 5, 0, 20, 8};
  localparam int PH_H [NUM_PHASES] = '{64, 1, 9, 64, 3, 0, 8};
  localparam int PH_N [NUM_PHASES] = '{400, 150, 350, 350, 50, 50, 600};
  localparam int PH_IDLE [NUM_PHASES] = '{38, 38, 38, 50, 50, 50, 0};

  // --------------------------------------------------------------------------
  // Film model and result queue
  // --------------------------------------------------------------------------
  class film_scoreboard;
    longint      chan_acc [NUM_CH][PIXELS];
    longint      weight_acc [PIXELS];
    int unsigned cols = IMAGE_WIDTH_RST;
    int unsigned rows = IMAGE_HEIGHT_RST;
    result_t     pixel_q [$];
    int unsigned fail_count;
    int unsigned shown;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) cols = val;
      else if (idx == CFG_IMAGE_HEIGHT) rows = val;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // floor(sum * 255 / (wsum * 4096)), clamped; non-positive sums read black
    function logic [BYTE_W-1:0] to_byte(longint acc, longint wacc);
      longint q;
      if (acc <= 0) return '0;
      q = (acc * 255) / (wacc <<< 12);
      return (q > 255) ? BYTE_MAX : BYTE_W'(q);
    endfunction

    function void note_item(cmd_t c);
      result_t           r;
      longint            w_eff, h_eff, wt, ws, s;
      longint            colour [NUM_CH];
      logic [BYTE_W-1:0] px [NUM_CH];
      int                addr, ch;
      bit                sat;
      r     = '0;
      sat   = 1'b0;
      w_eff = (cols < MAX_WIDTH_DEF) ? cols : MAX_WIDTH_DEF;
      h_eff = (rows < MAX_HEIGHT_DEF) ? rows : MAX_HEIGHT_DEF;
      if (longint'(c.x_pos) >= w_eff || longint'(c.y_pos) >= h_eff) begin
        r.status = ST_RANGE;
      end else begin
        addr        = int'(c.y_pos) * MAX_WIDTH_DEF + int'(c.x_pos);
        r.image_row = POS_W'(h_eff - 1 - longint'(c.y_pos));
        if (c.mode == MODE_ADD) begin
          wt        = longint'(c.sample_weight);
          colour[0] = longint'($signed(c.sample_red));
          colour[1] = longint'($signed(c.sample_green));
          colour[2] = longint'($signed(c.sample_blue));
          for (ch = 0; ch < NUM_CH; ch++) begin
            s = chan_acc[ch][addr] + colour[ch] * wt;
            if (s > ACC_TOP) begin
              s   = ACC_TOP;
              sat = 1'b1;
            end else if (s < ACC_BOT) begin
              s   = ACC_BOT;
              sat = 1'b1;
            end
            chan_acc[ch][addr] = s;
          end
          ws = weight_acc[addr] + wt;
          if (ws > WACC_TOP) begin
            ws  = WACC_TOP;
            sat = 1'b1;
          end
          weight_acc[addr] = ws;
          r.status = sat ? ST_SAT : ST_OK;
        end else begin
          ws = weight_acc[addr];
          if (ws == 0) begin
            r.status = ST_NO_WEIGHT;
          end else begin
            for (ch = 0; ch < NUM_CH; ch++) begin
              px[ch] = to_byte(chan_acc[ch][addr], ws);
              if (chan_acc[ch][addr] == ACC_TOP || chan_acc[ch][addr] == ACC_BOT)
                sat = 1'b1;
            end
            r.pixel_red   = px[0];
            r.pixel_green = px[1];
            r.pixel_blue  = px[2];
            r.status      = (sat || ws == WACC_TOP) ? ST_SAT : ST_OK;
          end
        end
      end
      pixel_q = {pixel_q, r};
    endfunction

    function void field_check(string tag, int want, int got);
      if (want == got) return;
      fail_count++;
      if (shown < SHOWN_MAX) begin
        shown++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pixel_q.size() == 0) begin
        fail_count++;
        if (shown < SHOWN_MAX) begin
          shown++;
          $display("%0t: stray result, expected none, got %h", $time, got);
        end
        return;
      end
      want = pixel_q.pop_front();
      field_check("status", want.status, got.status);
      field_check("pixel_red", want.pixel_red, got.pixel_red);
      field_check("pixel_green", want.pixel_green, got.pixel_green);
      field_check("pixel_blue", want.pixel_blue, got.pixel_blue);
      field_check("image_row", want.image_row, got.image_row);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  cmd_t                 cmd       = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;
  logic                 busy;
  logic                 done;
  result_t              result;
  logic                 cfg_ready;

  film_scoreboard sb = new;
  int             cycle_count = 0;

  // stimulus view of the film size and recently written pixels
  int eff_w = MAX_WIDTH_DEF;
  int eff_h = MAX_HEIGHT_DEF;
  int hot_x [HOT_SLOTS];
  int hot_y [HOT_SLOTS];
  int hot_n = 0;
  int hot_wr = 0;

  weighted_pixel_accumulate_resolve_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result strobe: checked at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[weighted_pixel_accumulate_resolve_top] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Item construction
  // --------------------------------------------------------------------------
  function automatic cmd_t make_cmd(logic mode, int x, int y, int r, int g, int b, int w);
    cmd_t c;
    c.mode          = mode;
    c.x_pos         = POS_W'(x);
    c.y_pos         = POS_W'(y);
    c.sample_red    = SAMPLE_W'(r);
    c.sample_green  = SAMPLE_W'(g);
    c.sample_blue   = SAMPLE_W'(b);
    c.sample_weight = SAMPLE_W'(w);
    return c;
  endfunction

  // mostly colors in [0, ~1.1] so resolved bytes land mid-range
  function automatic int pick_colour();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(4600);
    if (sel < 65) return -32768;
    if (sel < 70) return 32767;
    return int'($urandom);
  endfunction

  function automatic int pick_weight();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 0;
    if (sel == 1) return 65535;
    if (sel < 5) return $urandom_range(8192, 1);
    return int'($urandom);
  endfunction

  // resolves mostly revisit pixels that were just written
  function automatic cmd_t random_cmd();
    logic mode;
    int   x, y, k;
    mode = ($urandom_range(99) < 40) ? MODE_RESOLVE : MODE_ADD;
    if (eff_w == 0 || eff_h == 0 || $urandom_range(99) < 15) begin
      x = $urandom_range(63);
      y = $urandom_range(63);
    end else if (hot_n > 0 && $urandom_range(99) < ((mode == MODE_RESOLVE) ? 85 : 50)) begin
      k = $urandom_range(hot_n - 1);
      x = hot_x[k];
      y = hot_y[k];
    end else begin
      x = $urandom_range(eff_w - 1);
      y = $urandom_range(eff_h - 1);
      if (mode == MODE_ADD) begin
        hot_x[hot_wr] = x;
        hot_y[hot_wr] = y;
        hot_wr = (hot_wr + 1) % HOT_SLOTS;
        if (hot_n < HOT_SLOTS) hot_n++;
      end
    end
    return make_cmd(mode, x, y, pick_colour(), pick_colour(), pick_colour(), pick_weight());
  endfunction

  // --------------------------------------------------------------------------
  // Port tasks
  // --------------------------------------------------------------------------
  task automatic send_cmd(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(c);
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(45, 1)) @(posedge clk);
    end
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(CFG_IMAGE_WIDTH, REG_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, REG_W'(h));
    // unmapped index must not disturb either register
    write_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, REG_W'($urandom));
    cfg_valid <= 1'b0;
    eff_w  = (w < MAX_WIDTH_DEF) ? w : MAX_WIDTH_DEF;
    eff_h  = (h < MAX_HEIGHT_DEF) ? h : MAX_HEIGHT_DEF;
    hot_n  = 0;
    hot_wr = 0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int p, i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // corners, empty pixels, tiny and full weights at the reset size
    send_cmd(make_cmd(MODE_RESOLVE, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_ADD, 0, 0, 4096, 2048, -4096, 4096));
    send_cmd(make_cmd(MODE_RESOLVE, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_ADD, 63, 63, 32767, -32768, 0, 65535));
    send_cmd(make_cmd(MODE_RESOLVE, 63, 63, -1, -1, -1, 65535));
    send_cmd(make_cmd(MODE_ADD, 63, 0, -1, -1, -1, 0));
    send_cmd(make_cmd(MODE_RESOLVE, 63, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_ADD, 0, 63, 1, 0, 32767, 1));
    send_cmd(make_cmd(MODE_RESOLVE, 0, 63, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_ADD, 5, 7, 4095, 1000, 4096, 4096));
    send_cmd(make_cmd(MODE_ADD, 5, 7, 0, 3000, -4096, 12288));
    send_cmd(make_cmd(MODE_RESOLVE, 5, 7, 0, 0, 0, 0));
    wait_drained();

    // out-of-range positions on a reduced film
    set_size(32, 16);
    send_cmd(make_cmd(MODE_ADD, 40, 3, 4096, 4096, 4096, 4096));
    send_cmd(make_cmd(MODE_RESOLVE, 3, 20, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_ADD, 31, 15, 2000, 3000, 4000, 300));
    send_cmd(make_cmd(MODE_RESOLVE, 31, 15, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_RESOLVE, 32, 15, 0, 0, 0, 0));
    send_cmd(make_cmd(MODE_ADD, 0, 16, 100, 100, 100, 100));
    wait_drained();

    // random phases over several film sizes
    for (p = 0; p < NUM_PHASES; p++) begin
      set_size(PH_W[p], PH_H[p]);
      for (i = 0; i < PH_N[p]; i++) begin
        send_cmd(random_cmd());
        if (i == PH_N[p] - 1 || (p == 0 && i == PAUSE_AT)) wait_drained();
        else sender_gap(PH_IDLE[p]);
      end
    end

    if (sb.fail_count == 0) begin
      $display("[weighted_pixel_accumulate_resolve_top] OK");
    end else begin
      $display("[weighted_pixel_accumulate_resolve_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== weighted_pixel_accumulate_resolve_top.f =====
src/wpar_pkg.sv
src/wpar_ram.sv
src/wpar_div.sv
src/weighted_pixel_accumulate_resolve_top.sv
sim/testbench.sv
